>>> design/bba_pkg.sv
// Package for the bitmap block allocator: sizes, status codes and the
// reset contents of the used-block bitmap. No dependencies.
package bba_pkg;

  localparam int NUM_BLOCKS      = 1024;
  localparam int RESERVED_BLOCKS = 34;
  localparam int WORD_BITS       = 32;

  localparam int MAP_WORDS  = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_IDX_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BIT_IDX_W  = $clog2(WORD_BITS);
  localparam int ID_W       = 11;
  localparam int STATUS_W   = 2;

  // Reserved count saturates at the number of blocks.
  localparam int RSV_EFF = (RESERVED_BLOCKS < NUM_BLOCKS) ? RESERVED_BLOCKS : NUM_BLOCKS;

  localparam int LAST_VALID_BITS = NUM_BLOCKS - (MAP_WORDS - 1) * WORD_BITS;
  localparam logic [WORD_BITS-1:0] LAST_MASK =
    {WORD_BITS{1'b1}} >> (WORD_BITS - LAST_VALID_BITS);
  localparam logic [WORD_IDX_W-1:0] LAST_WORD = WORD_IDX_W'(MAP_WORDS - 1);
  localparam logic [ID_W-1:0] NUM_BLOCKS_ID = ID_W'(NUM_BLOCKS);

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  // Contents of one bitmap word right after reset.
  function automatic logic [WORD_BITS-1:0] reset_word(input logic [WORD_IDX_W-1:0] w);
    logic [WORD_BITS-1:0] r;
    r = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (int'(w) * WORD_BITS + b < RSV_EFF) begin
        r[b] = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

>>> design/bitmap_block_allocator_top.sv
// Sequence: a free of an out-of-range id answers in the cycle after acceptance; a
// valid free reads its bitmap word, then clears the bit in S_FREE; an allocate
// checks words from word 0 up in S_ALLOC and reports ST_FULL after the last word.
// Throughput: one request at a time; the single-port bitmap RAM is read one word
// per cycle during the search. done_o pulses for one cycle per request.
// Reset: asynchronous, active low; per-word valid flags make the map read as reset.
// Top level of the first-fit bitmap block allocator. Uses bba_pkg.
module bitmap_block_allocator_top
  import bba_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                kind_i,
  input  logic [ID_W-1:0]     block_id_i,
  output logic                done_o,
  output logic [ID_W-1:0]     granted_id_o,
  output logic [STATUS_W-1:0] status_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ALLOC = 2'd1;
  localparam logic [1:0] S_FREE  = 2'd2;

  logic [1:0] state_q, state_d;

  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rdata_q;
  logic [MAP_WORDS-1:0] vld_q;
  logic                 rvld_q;

  logic [WORD_IDX_W-1:0] word_q;
  logic [BIT_IDX_W-1:0]  bit_q;

  logic                  rd_en;
  logic [WORD_IDX_W-1:0] rd_addr;
  logic                  wr_en;
  logic [WORD_BITS-1:0]  wr_data;

  logic                  accept;
  logic                  id_bad;
  logic [ID_W-1:0]       id_m1;
  logic [WORD_BITS-1:0]  cur_word;
  logic [WORD_BITS-1:0]  search_word;
  logic                  found;
  logic [BIT_IDX_W-1:0]  free_bit;

  logic                  done_q, done_d;
  logic [ID_W-1:0]       granted_q, granted_d;
  logic [STATUS_W-1:0]   status_q, status_d;

  assign accept = start && (state_q == S_IDLE);
  assign id_bad = (block_id_i == '0) || (block_id_i > NUM_BLOCKS_ID);
  assign id_m1  = block_id_i - ID_W'(1);

  // A word never written since reset reads as its reset pattern.
  assign cur_word    = rvld_q ? rdata_q : reset_word(word_q);
  assign search_word = (word_q == LAST_WORD) ? (cur_word | ~LAST_MASK) : cur_word;

  always_comb begin
    found    = 1'b0;
    free_bit = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!search_word[b]) begin
        found    = 1'b1;
        free_bit = BIT_IDX_W'(b);
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    rd_en     = 1'b0;
    rd_addr   = word_q + WORD_IDX_W'(1);
    wr_en     = 1'b0;
    wr_data   = cur_word;
    done_d    = 1'b0;
    granted_d = granted_q;
    status_d  = status_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          if (kind_i == KIND_ALLOC) begin
            rd_en   = 1'b1;
            rd_addr = '0;
            state_d = S_ALLOC;
          end else if (id_bad) begin
            done_d    = 1'b1;
            granted_d = '0;
            status_d  = ST_RANGE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = id_m1[BIT_IDX_W +: WORD_IDX_W];
            state_d = S_FREE;
          end
        end
      end
      S_ALLOC: begin
        if (found) begin
          wr_en     = 1'b1;
          wr_data   = cur_word | (WORD_BITS'(1) << free_bit);
          done_d    = 1'b1;
          granted_d = ID_W'({word_q, free_bit}) + ID_W'(1);
          status_d  = ST_OK;
          state_d   = S_IDLE;
        end else if (word_q == LAST_WORD) begin
          done_d    = 1'b1;
          granted_d = '0;
          status_d  = ST_FULL;
          state_d   = S_IDLE;
        end else begin
          // Fetch the next word while this one is being checked.
          rd_en = 1'b1;
        end
      end
      S_FREE: begin
        wr_en     = 1'b1;
        wr_data   = cur_word & ~(WORD_BITS'(1) << bit_q);
        done_d    = 1'b1;
        granted_d = '0;
        status_d  = ST_OK;
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[word_q] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      vld_q   <= '0;
      rvld_q  <= 1'b0;
      word_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (wr_en) begin
        vld_q[word_q] <= 1'b1;
      end
      if (rd_en) begin
        rvld_q <= vld_q[rd_addr];
        word_q <= rd_addr;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      bit_q <= id_m1[BIT_IDX_W-1:0];
    end
    granted_q <= granted_d;
    status_q  <= status_d;
  end

  assign busy         = (state_q != S_IDLE);
  assign done_o       = done_q;
  assign granted_id_o = granted_q;
  assign status_o     = status_q;

endmodule

>>> design/bba_checker.sv
// Port-level checker for the bitmap block allocator, bound to the top level.
// Uses bba_pkg.
module bba_checker
  import bba_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic                kind_i,
  input logic [ID_W-1:0]     block_id_i,
  input logic                done_o,
  input logic [ID_W-1:0]     granted_id_o,
  input logic [STATUS_W-1:0] status_o
);

  // A bad free id is answered in the very next cycle.
  a_range_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && kind_i == KIND_FREE &&
     (block_id_i == '0 || block_id_i > NUM_BLOCKS_ID))
    |=> (done_o && status_o == ST_RANGE))
    else $error("out-of-range free not reported at once");

  // Every error result carries a zero id.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> (granted_id_o == '0))
    else $error("error result with nonzero id");

  // A granted id lies inside the managed range, and the status is a defined code.
  a_id_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (granted_id_o <= NUM_BLOCKS_ID && status_o != 2'd3))
    else $error("granted id or status out of range");

  // With no request in flight and none taken, no result follows.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!start && !busy) |=> !done_o)
    else $error("result with no request");

  // The block is never busy while a result is being shown.
  a_idle_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

endmodule

bind bitmap_block_allocator_top bba_checker u_bba_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .kind_i       (kind_i),
  .block_id_i   (block_id_i),
  .done_o       (done_o),
  .granted_id_o (granted_id_o),
  .status_o     (status_o)
);
